[rtl/sqp_pkg.sv]
`default_nettype none

package sqp_pkg;

    // Fixed-point formats.
    localparam int ANGLE_FRAC_BITS = 24;
    localparam int OUT_FRAC_BITS   = 30;
    localparam int ANGLE_W         = 32;
    localparam int OUT_W           = 32;
    localparam int COEF_FRAC       = 30;
    localparam int OUT_SHIFT       = COEF_FRAC - OUT_FRAC_BITS;

    // Width of the product of the angle magnitude and 2/pi, and the number of
    // fraction bits in it.
    localparam int TW = 2 * ANGLE_W;
    localparam int SH = ANGLE_FRAC_BITS + 32;

    // Working width of the Q30 polynomial values and of their products.
    localparam int VW = 33;
    localparam int PW = 2 * VW;

    localparam logic [ANGLE_W-1:0] TWO_OVER_PI = 32'hA2F9_836E;

    localparam logic signed [VW-1:0] ONE_Q  = VW'(1) << COEF_FRAC;
    localparam logic signed [VW-1:0] HALF_Q = VW'(1) << (COEF_FRAC - 1);

    // Sine polynomial coefficients, Q30.
    localparam logic signed [VW-1:0] SIN_K1 = $signed(VW'(32'h6487_C700));
    localparam logic signed [VW-1:0] SIN_K3 = -$signed(VW'(32'h2952_E800));
    localparam logic signed [VW-1:0] SIN_K5 = $signed(VW'(32'h04F6_CA50));

    // Cosine polynomial coefficients, Q30.
    localparam logic signed [VW-1:0] COS_K2 = -$signed(VW'(32'h4EF4_E700));
    localparam logic signed [VW-1:0] COS_K4 = $signed(VW'(32'h103B_0000));
    localparam logic signed [VW-1:0] COS_K6 = -$signed(VW'(32'h014E_5EEC));

    // Reduced angle handed from the range reduction to the polynomial pipeline.
    typedef struct packed {
        logic                   valid;
        logic [1:0]             quad;
        logic signed [VW-1:0]   rem;
    } t_red;

    // Polynomial results handed to the output stage.
    typedef struct packed {
        logic                   valid;
        logic [1:0]             quad;
        logic signed [VW-1:0]   sin_v;
        logic signed [VW-1:0]   cos_v;
    } t_poly;

    // Brings a product of two Q30 values back to Q30, rounding to nearest
    // with halves away from zero.
    function automatic logic signed [VW-1:0] rnd_q(input logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        logic [PW-1:0] h;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        h = (m + (PW'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
        return p[PW-1] ? -$signed(h[VW-1:0]) : $signed(h[VW-1:0]);
    endfunction

endpackage

`default_nettype wire

[rtl/sqp_reduce.sv]
`default_nettype none

module sqp_reduce (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic signed [sqp_pkg::ANGLE_W-1:0] i_angle,
    output sqp_pkg::t_red                        o_red
);
    import sqp_pkg::*;

    logic [2:0]             r_vld;
    logic                   r_neg1;
    logic [ANGLE_W-1:0]     r_mag1;
    logic                   r_neg2;
    logic [TW-1:0]          r_tmag2;
    logic [1:0]             r_quad3;
    logic signed [VW-1:0]   r_rem3;

    logic [ANGLE_W-1:0]     n_mag;
    logic [TW-1:0]          n_tmag;
    logic [SH-1:0]          n_frac;
    logic                   n_up;
    logic [SH-1:0]          n_rabs;
    logic [SH:0]            n_rsum;
    logic [30:0]            n_r30abs;
    logic                   n_rneg;
    logic [1:0]             n_qlo;
    logic [1:0]             n_quad;
    logic signed [VW-1:0]   n_rem;

    // Stage 1: magnitude of the angle.
    assign n_mag = i_angle[ANGLE_W-1] ? (ANGLE_W'(0) - ANGLE_W'(i_angle)) : ANGLE_W'(i_angle);

    // Stage 2: scale to quadrant units.
    assign n_tmag = r_mag1 * TWO_OVER_PI;

    // Stage 3: split into nearest whole quadrant and remainder. When the
    // fraction is a half or more the quadrant rounds up and the remainder
    // changes sign.
    assign n_frac   = r_tmag2[SH-1:0];
    assign n_up     = n_frac[SH-1];
    assign n_rabs   = n_up ? (SH'(0) - n_frac) : n_frac;
    assign n_rsum   = {1'b0, n_rabs} + ((SH+1)'(1) << (SH - 31));
    assign n_r30abs = n_rsum[SH:SH-30];
    assign n_rneg   = r_neg2 ^ n_up;
    assign n_rem    = n_rneg ? -$signed(VW'(n_r30abs)) : $signed(VW'(n_r30abs));
    assign n_qlo    = r_tmag2[SH+1:SH] + {1'b0, n_up};
    assign n_quad   = r_neg2 ? (2'd0 - n_qlo) : n_qlo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1  <= i_angle[ANGLE_W-1];
        r_mag1  <= n_mag;
        r_neg2  <= r_neg1;
        r_tmag2 <= n_tmag;
        r_quad3 <= n_quad;
        r_rem3  <= n_rem;
    end

    assign o_red.valid = r_vld[2];
    assign o_red.quad  = r_quad3;
    assign o_red.rem   = r_rem3;

`ifndef ASSERT_OFF
    // The remainder never leaves half a quadrant.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_rem3 <= HALF_Q && r_rem3 >= -HALF_Q))
        else $error("remainder outside half a quadrant");
`endif

endmodule

`default_nettype wire

[rtl/sqp_poly.sv]
`default_nettype none

module sqp_poly (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire sqp_pkg::t_red  i_red,
    output sqp_pkg::t_poly o_poly
);
    import sqp_pkg::*;

    logic [7:0]             r_vld;
    logic [1:0]             r_quad [8];
    logic signed [VW-1:0]   r_rem  [6];
    logic signed [VW-1:0]   r_sq   [2:6];

    logic signed [PW-1:0]   r_sqp1;
    logic signed [PW-1:0]   r_sp3;
    logic signed [PW-1:0]   r_cp3;
    logic signed [VW-1:0]   r_sa4;
    logic signed [VW-1:0]   r_ca4;
    logic signed [PW-1:0]   r_sp5;
    logic signed [PW-1:0]   r_cp5;
    logic signed [VW-1:0]   r_sa6;
    logic signed [VW-1:0]   r_ca6;
    logic signed [PW-1:0]   r_sp7;
    logic signed [PW-1:0]   r_cp7;
    logic signed [VW-1:0]   r_sv8;
    logic signed [VW-1:0]   r_cv8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_red.valid};
        end
    end

    // Horner evaluation in s = r*r, one multiply stage followed by one
    // rounding and accumulate stage.
    always_ff @(posedge i_clk) begin
        r_quad[0] <= i_red.quad;
        for (int i = 1; i < 8; i++) begin
            r_quad[i] <= r_quad[i-1];
        end
        r_rem[0] <= i_red.rem;
        for (int i = 1; i < 6; i++) begin
            r_rem[i] <= r_rem[i-1];
        end
        for (int i = 3; i < 7; i++) begin
            r_sq[i] <= r_sq[i-1];
        end

        r_sqp1   <= i_red.rem * i_red.rem;
        r_sq[2]  <= rnd_q(r_sqp1);
        r_sp3    <= SIN_K5 * r_sq[2];
        r_cp3    <= COS_K6 * r_sq[2];
        r_sa4    <= rnd_q(r_sp3) + SIN_K3;
        r_ca4    <= rnd_q(r_cp3) + COS_K4;
        r_sp5    <= r_sa4 * r_sq[4];
        r_cp5    <= r_ca4 * r_sq[4];
        r_sa6    <= rnd_q(r_sp5) + SIN_K1;
        r_ca6    <= rnd_q(r_cp5) + COS_K2;
        r_sp7    <= r_rem[5] * r_sa6;
        r_cp7    <= r_ca6 * r_sq[6];
        r_sv8    <= rnd_q(r_sp7);
        r_cv8    <= rnd_q(r_cp7) + ONE_Q;
    end

    assign o_poly.valid = r_vld[7];
    assign o_poly.quad  = r_quad[7];
    assign o_poly.sin_v = r_sv8;
    assign o_poly.cos_v = r_cv8;

`ifndef ASSERT_OFF
    // The square of a remainder within half a quadrant stays in [0, 0.25].
    a_sq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_sq[2] >= 0 && r_sq[2] <= (ONE_Q >>> 2)))
        else $error("square of remainder out of range");
`endif

endmodule

`default_nettype wire

[rtl/sqp_out.sv]
`default_nettype none

module sqp_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sqp_pkg::t_poly                i_poly,
    output logic                               o_valid,
    output logic signed [sqp_pkg::OUT_W-1:0]   o_sine,
    output logic signed [sqp_pkg::OUT_W-1:0]   o_cosine
);
    import sqp_pkg::*;

    localparam logic signed [OUT_W-1:0] OUT_ONE  = OUT_W'(1) << OUT_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] OUT_HALF = OUT_W'(1) << (OUT_FRAC_BITS - 1);

    logic                   r_vld1;
    logic                   r_vld2;
    logic signed [VW-1:0]   r_so1;
    logic signed [VW-1:0]   r_co1;
    logic signed [OUT_W-1:0] r_sine;
    logic signed [OUT_W-1:0] r_cosine;

    logic signed [VW-1:0]   n_so;
    logic signed [VW-1:0]   n_co;

    function automatic logic signed [VW-1:0] clamp_one(input logic signed [VW-1:0] v);
        if (v > ONE_Q) begin
            return ONE_Q;
        end else if (v < -ONE_Q) begin
            return -ONE_Q;
        end
        return v;
    endfunction

    // Rounds a clamped Q30 value to the output format, halves away from zero.
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [VW-1:0] v);
        logic [VW-1:0]          m;
        logic [VW-1:0]          h;
        logic signed [VW-1:0]   t;
        m = v[VW-1] ? VW'(-v) : VW'(v);
        h = (m + VW'((1 << OUT_SHIFT) >> 1)) >> OUT_SHIFT;
        if (h > (VW'(1) << OUT_FRAC_BITS)) begin
            h = VW'(1) << OUT_FRAC_BITS;
        end
        t = v[VW-1] ? -$signed(h) : $signed(h);
        return OUT_W'(t);
    endfunction

    // Odd quadrants swap the two polynomials; the upper quadrant bit negates.
    always_comb begin
        if (i_poly.quad[0]) begin
            n_so = i_poly.cos_v;
            n_co = -i_poly.sin_v;
        end else begin
            n_so = i_poly.sin_v;
            n_co = i_poly.cos_v;
        end
        if (i_poly.quad[1]) begin
            n_so = -n_so;
            n_co = -n_co;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_poly.valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_so1    <= clamp_one(n_so);
        r_co1    <= clamp_one(n_co);
        r_sine   <= to_out(r_so1);
        r_cosine <= to_out(r_co1);
    end

    assign o_valid  = r_vld2;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

`ifndef ASSERT_OFF
    a_sine_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |-> (r_sine <= OUT_ONE && r_sine >= -OUT_ONE))
        else $error("sine beyond plus or minus one");

    a_cosine_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |-> (r_cosine <= OUT_ONE && r_cosine >= -OUT_ONE))
        else $error("cosine beyond plus or minus one");

    // Sine and cosine of one angle can never both be small.
    a_not_both_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |-> (r_sine >= OUT_HALF || r_sine <= -OUT_HALF ||
                    r_cosine >= OUT_HALF || r_cosine <= -OUT_HALF))
        else $error("sine and cosine both below one half");
`endif

endmodule

`default_nettype wire

[rtl/sincos_quadrant_poly.sv]
`default_nettype none

// Sine and cosine of one angle per clock. An item is taken on every rising
// edge where start is high and busy is low; busy is high only while reset is
// held, so in normal operation an angle may be presented every cycle. The
// angle is signed Q8.24 radians, and each item yields one result: o_valid
// is high for a single cycle with o_sine and o_cosine in signed Q2.30,
// saturated to plus or minus 1.0. The receiver cannot hold results off, so
// it must take each result in the cycle it is shown. The pipeline has three
// stages of range reduction (magnitude, the 32 by 32 multiply by 2/pi, and
// the split into quadrant and remainder), eight stages of polynomial
// evaluation (four multiply stages, each followed by a rounding and
// accumulate stage), and two output stages (quadrant selection with
// clamping, then rounding to the output format). There is no state beyond
// the pipeline registers.
module sincos_quadrant_poly (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [sqp_pkg::ANGLE_W-1:0] i_angle,
    output logic                                   o_valid,
    output logic signed [sqp_pkg::OUT_W-1:0]        o_sine,
    output logic signed [sqp_pkg::OUT_W-1:0]        o_cosine
);
    import sqp_pkg::*;

    t_red   red;
    t_poly  poly;
    logic   accept;

    // The pipeline never stalls; it only refuses items while in reset.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    sqp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_angle),
        .o_red   (red)
    );

    sqp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_red   (red),
        .o_poly  (poly)
    );

    sqp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poly   (poly),
        .o_valid  (o_valid),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps

// Checks the sine/cosine block against a bit-exact predictor.
// An initial block loads angles into a pending queue in phases. A driver
// clocked on the falling edge presents them on start/i_angle. A monitor on
// the rising edge predicts each accepted item and checks every strobed result
// against the oldest prediction. The block has no state, so every angle is
// predicted on its own.
module tb;

    import sqp_pkg::ANGLE_W;
    import sqp_pkg::OUT_W;
    import sqp_pkg::ANGLE_FRAC_BITS;
    import sqp_pkg::OUT_FRAC_BITS;

    // Number of fraction bits in |angle| * 2/pi.
    localparam int QUAD_SHIFT = ANGLE_FRAC_BITS + 32;
    localparam longint unsigned INV_HALF_PI = 64'hA2F9_836E;

    // Polynomial coefficients and 1.0, all in Q30.
    localparam longint UNITY  = 64'sh4000_0000;
    localparam longint SIN_C1 = 64'sh6487_C700;
    localparam longint SIN_C3 = -64'sh2952_E800;
    localparam longint SIN_C5 = 64'sh04F6_CA50;
    localparam longint COS_C2 = -64'sh4EF4_E700;
    localparam longint COS_C4 = 64'sh103B_0000;
    localparam longint COS_C6 = -64'sh014E_5EEC;

    // Angles of pi/4 and multiples of pi/2 in Q8.24.
    localparam int EIGHTH_TURN  = 32'h00C9_0FDB;
    localparam int QUARTER_TURN = 32'h0192_1FB5;
    localparam int HALF_TURN    = 32'h0324_3F6A;
    localparam int FULL_TURN    = 32'h0648_7ED5;

    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic signed [OUT_W-1:0] sine;
        logic signed [OUT_W-1:0] cosine;
    } t_sincos;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic signed [ANGLE_W-1:0] i_angle = '0;
    logic                      busy;
    logic                      o_valid;
    logic signed [OUT_W-1:0]   o_sine;
    logic signed [OUT_W-1:0]   o_cosine;

    logic signed [ANGLE_W-1:0] angle_queue[$];
    t_sincos                   sincos_expected[$];

    // Percentage of free slots in which the driver holds start low.
    int unsigned idle_pct    = 0;
    int unsigned mismatches  = 0;
    int unsigned stall_count = 0;
    // Set when the item on start/i_angle was taken at the last rising edge.
    logic        took        = 1'b0;

    sincos_quadrant_poly DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

    always #1 i_clk = ~i_clk;

    // Divides by 2^n, rounding to nearest with ties away from zero.
    function automatic longint round_div(input longint v, input int n);
        longint unsigned m;
        if (n == 0) begin
            return v;
        end
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (n - 1))) >> n;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return round_div(a * b, 30);
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Saturates a Q30 value to +/-1.0 and brings it to the output format.
    function automatic logic signed [OUT_W-1:0] to_out_fmt(input longint v30);
        longint v;
        v = clamp(v30, UNITY);
        v = round_div(v, 30 - OUT_FRAC_BITS);
        v = clamp(v, longint'(1) << OUT_FRAC_BITS);
        return v[OUT_W-1:0];
    endfunction

    // Expected sine and cosine for one angle.
    function automatic t_sincos sincos_predict(input logic signed [ANGLE_W-1:0] angle);
        longint unsigned mag;
        longint unsigned tmag;
        longint unsigned qm;
        longint unsigned rabs;
        longint unsigned r30abs;
        longint          rm;
        longint          r;
        longint          s;
        longint          acc;
        longint          sv;
        longint          cv;
        longint          so;
        longint          co;
        logic            neg;
        logic            rneg;
        logic [1:0]      quad;
        t_sincos         res;
        neg  = angle[ANGLE_W-1];
        mag  = neg ? (64'h1_0000_0000 - {32'b0, angle}) : {32'b0, angle};
        tmag = mag * INV_HALF_PI;
        // Nearest quadrant, rounded on the magnitude so ties go away from zero.
        qm   = (tmag + (64'd1 << (QUAD_SHIFT - 1))) >> QUAD_SHIFT;
        rm   = longint'(tmag) - longint'(qm << QUAD_SHIFT);
        rneg = neg != (rm < 0);
        rabs = (rm < 0) ? longint'(-rm) : rm;
        r30abs = (rabs + (64'd1 << (QUAD_SHIFT - 31))) >> (QUAD_SHIFT - 30);
        r    = rneg ? -longint'(r30abs) : longint'(r30abs);
        quad = qm[1:0];
        if (neg) begin
            quad = -quad;
        end

        s = mul_q30(r, r);

        acc = mul_q30(SIN_C5, s) + SIN_C3;
        acc = mul_q30(acc, s) + SIN_C1;
        sv  = mul_q30(r, acc);

        acc = mul_q30(COS_C6, s) + COS_C4;
        acc = mul_q30(acc, s) + COS_C2;
        cv  = mul_q30(acc, s) + UNITY;

        // Odd quadrants swap the two polynomials; the upper half negates both.
        if (quad[0]) begin
            so = cv;
            co = -sv;
        end else begin
            so = sv;
            co = cv;
        end
        if (quad[1]) begin
            so = -so;
            co = -co;
        end
        res.sine   = to_out_fmt(so);
        res.cosine = to_out_fmt(co);
        return res;
    endfunction

    // Random angles: a mix of the full range, angles within one full turn of
    // zero, and points close to multiples of pi/4, where the quadrant rounding
    // flips and where the polynomials come nearest to 1.0.
    function automatic logic signed [ANGLE_W-1:0] random_angle();
        int pick;
        int k;
        int off;
        pick = $urandom_range(9);
        if (pick < 4) begin
            return $urandom;
        end
        if (pick < 7) begin
            return int'($urandom_range(2 * FULL_TURN)) - FULL_TURN;
        end
        k   = int'($urandom_range(300)) - 150;
        off = int'($urandom_range(64)) - 32;
        return k * EIGHTH_TURN + off;
    endfunction

    // Blocks until every queued angle has gone in and every result is out.
    task automatic drain();
        while (angle_queue.size() != 0 || start || sincos_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic load_random(input int count);
        repeat (count) angle_queue.push_back(random_angle());
    endtask

    // Driver: a slot is free when start is low or its item was just taken.
    // In a free slot the next angle goes out unless this slot is an idle one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (angle_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start   <= 1'b1;
                i_angle <= angle_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predicts each item as it is taken, then checks the strobed
    // result against the oldest prediction. The watchdog counts edges at which
    // neither an item nor a result moves.
    always @(posedge i_clk) begin : monitor
        t_sincos want;
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                sincos_expected.push_back(sincos_predict(i_angle));
            end
            if (o_valid) begin
                if (sincos_expected.size() == 0) begin
                    $error("result with none expected: sine %0d cosine %0d",
                           o_sine, o_cosine);
                    mismatches++;
                end else begin
                    want = sincos_expected.pop_front();
                    if (o_sine !== want.sine) begin
                        $error("sine: expected %0d, got %0d", want.sine, o_sine);
                        mismatches++;
                    end
                    if (o_cosine !== want.cosine) begin
                        $error("cosine: expected %0d, got %0d", want.cosine, o_cosine);
                        mismatches++;
                    end
                end
            end
            if ((start && !busy) || o_valid) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, issued back to back: zero and the smallest steps,
        // the two ends of the range, multiples of pi/2 (where the polynomials
        // may overshoot 1.0), angles next to pi/4 (the half-quadrant split),
        // and whole radians, whose remainder lands exactly on a rounding tie.
        idle_pct = 0;
        angle_queue.push_back(32'sd0);
        angle_queue.push_back(32'sd1);
        angle_queue.push_back(-32'sd1);
        angle_queue.push_back(32'h7FFF_FFFF);
        angle_queue.push_back(32'h8000_0000);
        angle_queue.push_back(32'h8000_0001);
        angle_queue.push_back(QUARTER_TURN);
        angle_queue.push_back(-QUARTER_TURN);
        angle_queue.push_back(HALF_TURN);
        angle_queue.push_back(-HALF_TURN);
        angle_queue.push_back(QUARTER_TURN + HALF_TURN);
        angle_queue.push_back(FULL_TURN);
        angle_queue.push_back(EIGHTH_TURN - 1);
        angle_queue.push_back(EIGHTH_TURN);
        angle_queue.push_back(EIGHTH_TURN + 1);
        angle_queue.push_back(-EIGHTH_TURN);
        angle_queue.push_back(-EIGHTH_TURN - 1);
        angle_queue.push_back(3 * EIGHTH_TURN);
        angle_queue.push_back(32'sh0100_0000);
        angle_queue.push_back(-32'sh0100_0000);
        angle_queue.push_back(32'sh0300_0000);
        angle_queue.push_back(-32'sh0300_0000);
        drain();

        // Random angles in three phases of sender idling. Each phase waits for
        // the pipeline to empty before the next one starts.
        @(posedge i_clk);
        idle_pct = 23;
        load_random(RANDOM_ITEMS / 3);
        drain();

        @(posedge i_clk);
        idle_pct = 65;
        load_random(RANDOM_ITEMS / 3);
        drain();

        @(posedge i_clk);
        idle_pct = 0;
        load_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain();

        // Wait out the tail so that a stray result would still be caught.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (sincos_expected.size() != 0) begin
            $error("%0d results never arrived", sincos_expected.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
